/* hdl/dshot_pkg.sv */
// shared types, constants and a helper function for the dshot frame encoder
`default_nettype none
package dshot_pkg;

   localparam int MOTORS = 4;
   localparam int VIS_MOTORS = (MOTORS < 4) ? MOTORS : 4;
   localparam int SLOTS = 64;
   localparam int PKT_W = 16;
   localparam int MUL_STEPS = 11;

   localparam logic [15:0] Q16_MAX = 16'd65470;
   localparam logic [10:0] BI_SPAN = 11'd1000;
   localparam logic [10:0] UNI_SPAN = 11'd2001;
   localparam logic [11:0] FWD_BASE = 12'd48;
   localparam logic [11:0] REV_BASE = 12'd1048;

   localparam logic [8:0] IDLE_OFFSET_RST = 9'd40;
   localparam logic [19:0] FS_TIMEOUT_RST = 20'd100000;

   localparam logic [1:0] CSR_IDLE_OFFSET = 2'd0;
   localparam logic [1:0] CSR_BIDIR_MODE = 2'd1;
   localparam logic [1:0] CSR_SPIN_DIR = 2'd2;
   localparam logic [1:0] CSR_FS_TIMEOUT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_PACK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      FS_OFF,
      FS_TIMING,
      FS_EXPIRED
   } fs_phase_type;

   typedef logic [MOTORS-1:0][PKT_W-1:0] pkt_array_type;

   typedef struct packed {
      logic        done;
      logic [26:0] product;
   } mul_stat_type;

   typedef struct packed {
      logic done;
      logic busy;
   } slot_stat_type;

   // 12-bit word (value, telemetry 0) followed by nibble-xor checksum
   function automatic logic [PKT_W-1:0] build_packet(input logic [10:0] value);
      logic [11:0] word;
      logic [3:0]  csum;
      word = {value, 1'b0};
      csum = word[3:0] ^ word[7:4] ^ word[11:8];
      return {word, csum};
   endfunction

endpackage
`default_nettype wire

/* hdl/dshot_mul.sv */
// shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module dshot_mul
   import dshot_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [15:0]  mcand,
   input  wire logic [10:0]  mplier,
   output mul_stat_type      stat
);

   logic [26:0] acc_ff, acc_in;
   logic [26:0] mcand_ff, mcand_in;
   logic [10:0] mplier_ff, mplier_in;
   logic [3:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      step_in = step_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = {11'd0, mcand};
         mplier_in = mplier;
         step_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[25:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[10:1]};
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(MUL_STEPS - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign stat.done = done_ff;
   assign stat.product = acc_ff;

endmodule
`default_nettype wire

/* hdl/dshot_slot.sv */
// slot serializer: walks the 64 slots of a frame under the response handshake
`default_nettype none
module dshot_slot
   import dshot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire pkt_array_type     packets,
   input  wire logic [MOTORS-1:0] written,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [3:0]             rsp_pin_levels,
   output logic                   rsp_last_slot,
   output slot_stat_type          stat
);

   logic [5:0] slot_ff, slot_in;
   logic       active_ff, active_in;
   logic [3:0] bitpos;
   logic [1:0] phase;
   logic       fire;

   assign fire = active_ff && rsp_ready;

   always_comb begin
      slot_in = slot_ff;
      active_in = active_ff;
      if (start) begin
         slot_in = '0;
         active_in = 1'b1;
      end else if (fire) begin
         slot_in = slot_ff + 6'd1;
         if (slot_ff == 6'(SLOTS - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         active_ff <= active_in;
         slot_ff <= slot_in;
      end
   end

   assign bitpos = 4'd15 - slot_ff[5:2];
   assign phase = slot_ff[1:0];

   always_comb begin
      rsp_pin_levels = '0;
      for (int m = 0; m < VIS_MOTORS; m++) begin
         if (written[m]) begin
            case (phase)
               2'd0: rsp_pin_levels[m] = 1'b1;
               2'd3: rsp_pin_levels[m] = 1'b0;
               default: rsp_pin_levels[m] = packets[m][bitpos];
            endcase
         end
      end
   end

   assign rsp_valid = active_ff;
   assign rsp_last_slot = active_ff && (slot_ff == 6'(SLOTS - 1));
   assign stat.done = fire && (slot_ff == 6'(SLOTS - 1));
   assign stat.busy = active_ff;

endmodule
`default_nettype wire

/* hdl/dshot_frame_encoder_top.sv */
// dshot frame encoder top: sequencer, packet store, failsafe timer and config
// a request passes through prep, 11 multiplier steps, a done check and pack
// a last-motor request then emits 64 slot responses, one per cycle when rsp_ready holds
// a new request is taken only in idle, after the previous request and any frame it emits
// the shared shift-add multiplier and the slot walk set the request timing
// reset: synchronous active high; clears packets, sets failsafe expired and config defaults
`default_nettype none
module dshot_frame_encoder_top
   import dshot_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_motor,
   input  wire logic signed [17:0] req_throttle,
   input  wire logic        req_on_ground,
   input  wire logic        req_failsafe_active,
   input  wire logic [31:0] req_now_us,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_pin_levels,
   output logic             rsp_last_slot,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);

   state_type     state_ff, state_in;
   fs_phase_type  phase_ff, phase_in;
   logic [31:0]   fs_start_ff, fs_start_in;
   logic          force_ff, force_in;

   logic [8:0]    idle_ff;
   logic          bidir_ff;
   logic          spin_ff;
   logic [19:0]   timeout_ff;

   logic [1:0]    motor_ff;
   logic [17:0]   throttle_ff;
   logic          ground_ff;
   logic          fsact_ff;
   logic [31:0]   now_ff;

   pkt_array_type     store_ff, store_in;
   logic [MOTORS-1:0] written_ff, written_in;

   mul_stat_type  mul_stat;
   slot_stat_type slot_stat;
   logic          mul_start;
   logic          slot_start;
   logic          req_fire;

   logic [15:0]   t_clamp;
   logic [10:0]   span;
   logic [11:0]   base;
   logic [11:0]   sum;
   logic [10:0]   value;
   logic [31:0]   fs_diff;
   logic          fs_over;
   logic          motor_ok;
   logic          motor_last;

   assign req_fire = req_valid && req_ready;
   assign motor_ok = {30'd0, motor_ff} < 32'(MOTORS);
   assign motor_last = {30'd0, motor_ff} == 32'(MOTORS - 1);

   // clamp and scale
   always_comb begin
      if (throttle_ff[17]) begin
         t_clamp = '0;
      end else if (throttle_ff[16:0] > {1'b0, Q16_MAX}) begin
         t_clamp = Q16_MAX;
      end else begin
         t_clamp = throttle_ff[15:0];
      end
      if (bidir_ff) begin
         span = BI_SPAN - {2'd0, idle_ff};
         base = (spin_ff ? REV_BASE : FWD_BASE) + {3'd0, idle_ff};
      end else begin
         span = UNI_SPAN - {1'b0, idle_ff, 1'b0};
         base = FWD_BASE + {2'd0, idle_ff, 1'b0};
      end
      sum = base + {1'b0, mul_stat.product[26:16]};
      value = force_ff ? 11'd0 : sum[10:0];
   end

   assign fs_diff = now_ff - fs_start_ff;
   assign fs_over = fs_diff > {12'd0, timeout_ff};

   dshot_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (t_clamp),
      .mplier (span),
      .stat   (mul_stat)
   );

   dshot_slot u_slot (
      .clock          (clock),
      .reset          (reset),
      .start          (slot_start),
      .packets        (store_ff),
      .written        (written_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_pin_levels (rsp_pin_levels),
      .rsp_last_slot  (rsp_last_slot),
      .stat           (slot_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_stat.done) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: state_in = (motor_ok && motor_last) ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (slot_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      slot_start = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_PREP: mul_start = 1'b1;
         ST_PACK: slot_start = motor_ok && motor_last;
         default: ;
      endcase
   end

   // failsafe and packet store
   always_comb begin
      phase_in = phase_ff;
      fs_start_in = fs_start_ff;
      force_in = force_ff;
      store_in = store_ff;
      written_in = written_ff;
      if (state_ff == ST_PREP) begin
         force_in = ground_ff;
         if (fsact_ff) begin
            case (phase_ff)
               FS_OFF: begin
                  fs_start_in = now_ff;
                  phase_in = FS_TIMING;
               end
               FS_TIMING: begin
                  if (fs_over) begin
                     phase_in = FS_EXPIRED;
                     force_in = 1'b1;
                  end
               end
               default: force_in = 1'b1;
            endcase
         end else begin
            phase_in = FS_OFF;
         end
      end
      if (state_ff == ST_PACK && motor_ok) begin
         store_in[motor_ff] = store_ff[motor_ff] | build_packet(value);
         written_in[motor_ff] = 1'b1;
      end
      if (state_ff == ST_EMIT && slot_stat.done) begin
         store_in = '0;
         written_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= FS_EXPIRED;
         fs_start_ff <= '0;
         force_ff <= 1'b0;
         store_ff <= '0;
         written_ff <= '0;
         idle_ff <= IDLE_OFFSET_RST;
         bidir_ff <= 1'b0;
         spin_ff <= 1'b0;
         timeout_ff <= FS_TIMEOUT_RST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fs_start_ff <= fs_start_in;
         force_ff <= force_in;
         store_ff <= store_in;
         written_ff <= written_in;
         if (csr_we) begin
            case (csr_index)
               CSR_IDLE_OFFSET: idle_ff <= csr_wdata[8:0];
               CSR_BIDIR_MODE: bidir_ff <= csr_wdata[0];
               CSR_SPIN_DIR: spin_ff <= csr_wdata[0];
               CSR_FS_TIMEOUT: timeout_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_fire) begin
         motor_ff <= req_motor;
         throttle_ff <= req_throttle;
         ground_ff <= req_on_ground;
         fsact_ff <= req_failsafe_active;
         now_ff <= req_now_us;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a frame is being sent");

   a_last_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_slot |-> rsp_pin_levels == 4'd0)
      else $error("last slot of a frame not low");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_slot |=> req_ready && !rsp_valid)
      else $error("block not idle after frame end");

   a_store_clear: assert property (@(posedge clock) disable iff (reset)
      slot_stat.done |=> written_ff == '0)
      else $error("packets not cleared after frame");
`endif

endmodule
`default_nettype wire
